// ----- sv/mlpq_pkg.sv -----
`timescale 1ns / 1ps

package mlpq_pkg;

  // defaults for the top-level parameters
  localparam int NUM_LEVELS_DEF  = 8;
  localparam int LEVEL_DEPTH_DEF = 16;

  // field widths
  localparam int VALUE_W  = 32;
  localparam int LEVEL_W  = 4;
  localparam int LEVELS_W = 4;
  localparam int DEPTH_W  = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // register reset values
  localparam logic [LEVELS_W-1:0] LEVELS_RST = 4'd8;
  localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 5'd16;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_LEVEL = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVELS = 1'b0,
    CFG_DEPTH  = 1'b1
  } cfg_reg_t;

  // result of the level search
  typedef struct packed {
    logic               found;
    logic [LEVEL_W-1:0] level_idx;
  } grant_t;

endpackage

// ----- sv/multi_level_priority_queue.sv -----
`timescale 1ns / 1ps

// the result strobe is registered and comes in the cycle after the item is accepted
// throughput: one item per cycle, busy never rises; the slot memory is read
// or written once per item and its read data is registered
// reset: synchronous active-low rst_n empties every level and restores
// levels_in_use to 8 and depth_in_use to 16; slot contents are not cleared
module multi_level_priority_queue #(
  parameter int NUM_LEVELS  = mlpq_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request side
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic signed [mlpq_pkg::VALUE_W-1:0] in_item_value,
  input  logic [mlpq_pkg::LEVEL_W-1:0]      in_item_level,
  // result side
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [mlpq_pkg::VALUE_W-1:0] out_value,
  output logic [mlpq_pkg::LEVEL_W-1:0]      out_level,
  // configuration
  input  logic                              cfg_we,
  input  logic [mlpq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlpq_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // configuration registers
  logic [mlpq_pkg::LEVELS_W-1:0] levels_r;
  logic [mlpq_pkg::DEPTH_W-1:0]  depth_r;

  // per-level queue state
  logic [PTR_W-1:0] head_r  [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r  [NUM_LEVELS];
  logic [CNT_W-1:0] count_r [NUM_LEVELS];

  // slot storage, one row of LEVEL_DEPTH slots per level
  logic [mlpq_pkg::VALUE_W-1:0] slot_mem [SLOTS];
  logic [mlpq_pkg::VALUE_W-1:0] rdata_r;

  // result register
  logic                   out_valid_r;
  mlpq_pkg::status_t      status_r;
  logic [mlpq_pkg::LEVEL_W-1:0] level_r;
  logic                   deq_ok_r;

  logic                   accept;
  logic                   is_deq;
  logic [mlpq_pkg::LEVELS_W-1:0] levels_act;
  logic [CNT_W-1:0]       depth_act;
  logic [NUM_LEVELS-1:0]  nonempty;
  mlpq_pkg::grant_t       grant;
  logic                   lvl_ok;
  logic [LVL_W-1:0]       sel;
  logic [PTR_W-1:0]       ptr_sel;
  logic [CNT_W-1:0]       cnt_sel;
  logic [CNT_W-1:0]       ptr_inc;
  logic [PTR_W-1:0]       ptr_adv;
  logic [ADDR_W-1:0]      addr;
  logic                   enq_ok;
  logic                   deq_ok;
  mlpq_pkg::status_t      status_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_deq = (in_req_type == mlpq_pkg::REQ_DEQ);

  // levels saturate at NUM_LEVELS; depth 0 acts as 1 and saturates at LEVEL_DEPTH
  assign levels_act = (levels_r > mlpq_pkg::LEVELS_W'(NUM_LEVELS))
                      ? mlpq_pkg::LEVELS_W'(NUM_LEVELS) : levels_r;

  always_comb begin
    if (depth_r == '0) begin
      depth_act = CNT_W'(1);
    end else if (32'(depth_r) > LEVEL_DEPTH) begin
      depth_act = CNT_W'(LEVEL_DEPTH);
    end else begin
      depth_act = CNT_W'(depth_r);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (count_r[i] != '0);
    end
  end

  mlpq_pick #(
    .NUM_LEVELS(NUM_LEVELS)
  ) u_pick (
    .nonempty  (nonempty),
    .levels_act(levels_act),
    .grant     (grant)
  );

  // enqueue level check, levels are numbered from 1
  assign lvl_ok = (in_item_level != '0) &&
                  (in_item_level <= mlpq_pkg::LEVEL_W'(levels_act));

  // one level is touched per item: the granted one on dequeue, the named one on enqueue
  assign sel     = is_deq ? LVL_W'(grant.level_idx) : LVL_W'(in_item_level - 4'd1);
  assign ptr_sel = is_deq ? head_r[sel] : tail_r[sel];
  assign cnt_sel = count_r[sel];

  // pointer advance with wrap at the current depth
  assign ptr_inc = CNT_W'(ptr_sel) + CNT_W'(1);
  assign ptr_adv = (ptr_inc >= depth_act) ? '0 : PTR_W'(ptr_inc);

  assign addr = ADDR_W'(sel) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ptr_sel);

  assign enq_ok = !is_deq && lvl_ok && (cnt_sel < depth_act);
  assign deq_ok = is_deq && grant.found;

  always_comb begin
    if (is_deq) begin
      status_nxt = grant.found ? mlpq_pkg::ST_DONE : mlpq_pkg::ST_EMPTY;
    end else if (!lvl_ok) begin
      status_nxt = mlpq_pkg::ST_BAD_LEVEL;
    end else if (cnt_sel >= depth_act) begin
      status_nxt = mlpq_pkg::ST_FULL;
    end else begin
      status_nxt = mlpq_pkg::ST_DONE;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= mlpq_pkg::LEVELS_RST;
      depth_r  <= mlpq_pkg::DEPTH_RST;
    end else if (cfg_we) begin
      case (mlpq_pkg::cfg_reg_t'(cfg_index))
        mlpq_pkg::CFG_LEVELS: levels_r <= cfg_wdata[mlpq_pkg::LEVELS_W-1:0];
        mlpq_pkg::CFG_DEPTH:  depth_r  <= cfg_wdata[mlpq_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // pointers and counts of the selected level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (accept) begin
      if (enq_ok) begin
        tail_r[sel]  <= ptr_adv;
        count_r[sel] <= cnt_sel + CNT_W'(1);
      end else if (deq_ok) begin
        head_r[sel]  <= ptr_adv;
        count_r[sel] <= cnt_sel - CNT_W'(1);
      end
    end
  end

  // slot memory: one write or one registered read per item
  always_ff @(posedge clk) begin
    if (accept && enq_ok) begin
      slot_mem[addr] <= in_item_value;
    end
    if (accept && deq_ok) begin
      rdata_r <= slot_mem[addr];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      deq_ok_r <= deq_ok;
      level_r  <= deq_ok ? mlpq_pkg::LEVEL_W'(grant.level_idx + 4'd1) : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_level  = level_r;
  assign out_value  = deq_ok_r ? rdata_r : '0;

`ifndef NO_ASSERTIONS
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result strobe");

  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result strobe without an accepted item");

  a_deq_done_has_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && deq_ok_r) |-> (out_level != '0 && out_status == mlpq_pkg::ST_DONE))
    else $error("served item carries no level");

  a_empty_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == mlpq_pkg::ST_EMPTY) |-> (out_level == '0 && out_value == '0))
    else $error("empty result carries a payload");

  a_no_empty_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_deq && nonempty[0] && levels_act != '0) |=>
      (out_status == mlpq_pkg::ST_DONE && out_level == 4'd1))
    else $error("level one pending but not served");
`endif

endmodule

// ----- sv/mlpq_pick.sv -----
`timescale 1ns / 1ps

// lowest-numbered non-empty level among the levels in use
module mlpq_pick #(
  parameter int NUM_LEVELS = mlpq_pkg::NUM_LEVELS_DEF
) (
  input  logic [NUM_LEVELS-1:0]        nonempty,
  input  logic [mlpq_pkg::LEVELS_W-1:0] levels_act,
  output mlpq_pkg::grant_t             grant
);

  always_comb begin
    grant.found     = 1'b0;
    grant.level_idx = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i] && (mlpq_pkg::LEVELS_W'(i) < levels_act)) begin
        grant.found     = 1'b1;
        grant.level_idx = mlpq_pkg::LEVEL_W'(i);
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mlpq_pkg::*;

  localparam int NLEV       = NUM_LEVELS_DEF;
  localparam int NDEPTH     = LEVEL_DEPTH_DEF;
  localparam int PTR_W      = $clog2(NDEPTH);
  localparam int RAND_ITEMS = 800;

  // shadow of the queues: predicts the result of every accepted item
  class mlpq_scoreboard;
    typedef struct packed {
      status_t            status;
      logic [VALUE_W-1:0] value;
      logic [LEVEL_W-1:0] level;
    } result_t;

    logic [VALUE_W-1:0]  slot_mem  [NLEV][NDEPTH];
    bit                  slot_seen [NLEV][NDEPTH];
    logic [PTR_W-1:0]    rd_ptr [NLEV];
    logic [PTR_W-1:0]    wr_ptr [NLEV];
    logic [PTR_W:0]      fill   [NLEV];
    logic [LEVELS_W-1:0] levels_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    result_t             pending_results [$];
    int                  mismatch_count;

    function new();
      foreach (slot_mem[q, s]) begin
        slot_mem[q][s]  = '0;
        slot_seen[q][s] = 1'b0;
      end
      foreach (fill[q]) begin
        rd_ptr[q] = '0;
        wr_ptr[q] = '0;
        fill[q]   = '0;
      end
      levels_reg     = LEVELS_RST;
      depth_reg      = DEPTH_RST;
      mismatch_count = 0;
    endfunction

    function int active_levels();
      return (levels_reg > NLEV) ? NLEV : int'(levels_reg);
    endfunction

    function int active_depth();
      if (depth_reg == 0) return 1;
      return (depth_reg > NDEPTH) ? NDEPTH : int'(depth_reg);
    endfunction

    function logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] ptr);
      int nxt;
      nxt = int'(ptr) + 1;
      return (nxt >= active_depth()) ? '0 : nxt[PTR_W-1:0];
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
      if (idx == CFG_LEVELS) levels_reg = data[LEVELS_W-1:0];
      else depth_reg = data[DEPTH_W-1:0];
    endfunction

    function int queued_total();
      int sum;
      sum = 0;
      foreach (fill[q]) sum += int'(fill[q]);
      return sum;
    endfunction

    // a depth change may only leave a level out of step if all its slots hold data
    function bit depth_change_ok();
      bit all_seen;
      foreach (fill[q]) begin
        all_seen = 1'b1;
        for (int s = 0; s < NDEPTH; s++) all_seen &= slot_seen[q][s];
        if (!all_seen && !(fill[q] == 0 && rd_ptr[q] == wr_ptr[q])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(req_t req, logic [VALUE_W-1:0] val, logic [LEVEL_W-1:0] lvl);
      result_t r;
      int      q;
      bit      found;
      r     = '{status: ST_DONE, value: '0, level: '0};
      found = 1'b0;
      if (req == REQ_ENQ) begin
        if (lvl < 1 || lvl > active_levels()) begin
          r.status = ST_BAD_LEVEL;
        end else begin
          q = int'(lvl) - 1;
          if (fill[q] >= active_depth()) begin
            r.status = ST_FULL;
          end else begin
            slot_mem[q][wr_ptr[q]]  = val;
            slot_seen[q][wr_ptr[q]] = 1'b1;
            wr_ptr[q] = next_slot(wr_ptr[q]);
            fill[q]   = fill[q] + 1'b1;
          end
        end
      end else begin
        for (q = 0; q < active_levels() && !found; q++) begin
          if (fill[q] != 0) begin
            found     = 1'b1;
            r.value   = slot_mem[q][rd_ptr[q]];
            r.level   = LEVEL_W'(q + 1);
            rd_ptr[q] = next_slot(rd_ptr[q]);
            fill[q]   = fill[q] - 1'b1;
          end
        end
        if (!found) r.status = ST_EMPTY;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [VALUE_W-1:0] val,
                               logic [LEVEL_W-1:0] lvl);
      result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d value %h level %0d",
                 $time, st, val, lvl);
        mismatch_count++;
        return;
      end
      r = pending_results.pop_front();
      if (st !== r.status) begin
        $display("%0t: status expected %0d got %0d", $time, r.status, st);
        mismatch_count++;
      end
      if (val !== r.value) begin
        $display("%0t: value expected %h got %h", $time, r.value, val);
        mismatch_count++;
      end
      if (lvl !== r.level) begin
        $display("%0t: level expected %0d got %0d", $time, r.level, lvl);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_req_type;
  logic signed [VALUE_W-1:0] in_item_value;
  logic [LEVEL_W-1:0]    in_item_level;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic signed [VALUE_W-1:0] out_value;
  logic [LEVEL_W-1:0]    out_level;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  mlpq_scoreboard sb;
  bit             no_idle;   // set for stretches with back-to-back items

  multi_level_priority_queue dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net in case the block hangs
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // results are sampled at the edge that ends their strobe cycle
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(out_status, out_value, out_level);
  end

  // mostly no gap, some short ones, the odd long one
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // level counts at and beyond the legal edges, bit 4 of the write data included
  function automatic logic [CFG_W-1:0] pick_levels();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd8;
      3: return 5'h1f;
      default: return CFG_W'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_depth();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  // drive one item and hold it until the block takes it
  task automatic send_item(req_t req, logic [VALUE_W-1:0] val, logic [LEVEL_W-1:0] lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_item_value <= val;
    in_item_level <= lvl;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(req, val, lvl);
  endtask

  // dequeues carry random junk in the ignored fields
  task automatic send_deq(int n);
    repeat (n) send_item(REQ_DEQ, $urandom, LEVEL_W'($urandom_range(0, 15)));
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // cfg_we is dropped again after the write, which keeps back-to-back writes apart
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int             sent;
    int             phase_len;
    int             enq_pct;
    int             nlev;
    int             drain;
    logic [LEVEL_W-1:0] lvl;

    sb      = new();
    no_idle = 1'b0;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_req_type   <= REQ_ENQ;
    in_item_value <= '0;
    in_item_level <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_LEVELS;
    cfg_wdata     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dequeue, bad levels, extreme values, zero as a real item
    send_deq(1);
    send_item(REQ_ENQ, 32'h0000_0001, 4'd0);
    send_item(REQ_ENQ, 32'hffff_ffff, 4'd15);
    send_item(REQ_ENQ, 32'h8000_0000, 4'd8);
    send_item(REQ_ENQ, 32'h0000_0000, 4'd1);
    send_item(REQ_ENQ, 32'h7fff_ffff, 4'd3);
    send_item(REQ_ENQ, 32'hffff_ffff, 4'd1);
    send_deq(5);

    // tiny depth so a level fills up
    wait_idle();
    write_reg(CFG_DEPTH, 5'd2);
    repeat (3) send_item(REQ_ENQ, $urandom, 4'd2);

    // hide the occupied level behind a single-level setting
    wait_idle();
    write_reg(CFG_LEVELS, 5'd1);
    send_deq(1);
    send_item(REQ_ENQ, $urandom, 4'd2);

    // level count above the number of levels saturates, hidden items come back
    wait_idle();
    write_reg(CFG_LEVELS, 5'h1f);
    send_item(REQ_ENQ, $urandom, 4'd8);
    send_deq(3);

    // depth of zero behaves as one
    wait_idle();
    write_reg(CFG_DEPTH, 5'd0);
    repeat (2) send_item(REQ_ENQ, $urandom, 4'd4);
    send_deq(1);

    // no levels at all
    wait_idle();
    write_reg(CFG_LEVELS, 5'd0);
    send_item(REQ_ENQ, $urandom, 4'd1);
    send_deq(1);

    // back to full size, depth above the maximum saturates
    wait_idle();
    write_reg(CFG_LEVELS, 5'd8);
    write_reg(CFG_DEPTH, 5'd31);

    // fill the two top levels past capacity so every slot there holds data
    no_idle = 1'b1;
    for (int k = 0; k < 34; k++) send_item(REQ_ENQ, $urandom, LEVEL_W'(k % 2 + 1));
    no_idle = 1'b0;

    // shrink the depth under queued items: counts above depth, pointers past the wrap
    wait_idle();
    write_reg(CFG_DEPTH, 5'd5);

    // random phases, registers retuned between them
    sent = 0;
    while (sent < RAND_ITEMS) begin
      phase_len = $urandom_range(15, 70);
      enq_pct   = $urandom_range(20, 85);
      no_idle   = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        nlev = sb.active_levels();
        if ($urandom_range(0, 99) < enq_pct) begin
          if (nlev > 0 && $urandom_range(0, 9) != 0)
            lvl = LEVEL_W'($urandom_range(1, nlev));
          else
            lvl = LEVEL_W'($urandom_range(0, 15));
          send_item(REQ_ENQ, $urandom, lvl);
        end else begin
          send_deq(1);
        end
        sent++;
      end
      no_idle = 1'b0;
      wait_idle();
      if ($urandom_range(0, 2) != 0) write_reg(CFG_LEVELS, pick_levels());
      if ($urandom_range(0, 1) == 0) begin
        // drain first where a partly written level would fall out of step
        if (!sb.depth_change_ok()) begin
          write_reg(CFG_LEVELS, 5'd8);
          drain = sb.queued_total();
          send_deq(drain);
          sent += drain;
          wait_idle();
        end
        write_reg(CFG_DEPTH, pick_depth());
      end
    end

    // let any stray result show up before the verdict
    wait_idle();
    repeat (5) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
